// ===== sv/ncbg_pkg.sv =====
`timescale 1ns / 1ps
package ncbg_pkg;

    // Frame counts are capped at 480, so nine bits hold any index or total.
    localparam int FRAME_W    = 9;
    localparam int MAX_FRAMES = 480;
    localparam int MIN_MS     = 5;
    localparam int MAX_MS     = 30;

    // Envelope numerator: a 15-bit peak times a 9-bit frame count.
    localparam int NUM_W = 24;
    localparam int DEN_W = FRAME_W;
    localparam int AMP_W = 15;

    localparam int SAMPLE_W = 16;
    localparam int RNG_W    = 32;

    // Configuration register indexes.
    localparam logic CFG_SOUND_ENABLED  = 1'b0;
    localparam logic CFG_VOLUME_PERCENT = 1'b1;

    // Input commands.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   numerator;
        logic [DEN_W-1:0]   denominator;
    } div_req_t;

endpackage

// ===== sv/ncbg_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ncbg_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ncbg_pkg::div_req_t          req,
    output logic                        done,
    output logic [ncbg_pkg::NUM_W-1:0]  quotient
);

    localparam int NUM_W = ncbg_pkg::NUM_W;
    localparam int DEN_W = ncbg_pkg::DEN_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Shift the next numerator bit into the partial remainder and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.denominator;
            rem_reg <= '0;
            quo_reg <= req.numerator;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/noise_click_burst_generator.sv =====
`timescale 1ns / 1ps
// Sequence: during a burst a tick transfer yields its sample after the envelope
// numerator, the restoring divide, the multiply and truncation; an idle tick goes straight to output.
// One item at a time: the next tick is taken only once the previous sample is registered
// for output, which for a burst tick is bounded by the divider. A start transfer gives
// no output. A held output register stalls the input until it drains.
// Reset (rst_n low, asynchronous): burst idle, generator word 1, sound enabled,
// volume 50, output empty.
module noise_click_burst_generator
#(
    parameter int FRAMES_PER_MS  = 16,
    parameter int PEAK_AMPLITUDE = 18000
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] duration_ms, [47:16] seed_value
    input  logic [0:0]  s_tuser,   // [0] command
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample
    output logic [0:0]  m_tuser,   // [0] active
    output logic        m_tlast    // last sample of the burst
);

    localparam int FRAME_W   = ncbg_pkg::FRAME_W;
    localparam int NUM_W     = ncbg_pkg::NUM_W;
    localparam int AMP_W     = ncbg_pkg::AMP_W;
    localparam int SAMPLE_W  = ncbg_pkg::SAMPLE_W;
    localparam int RNG_W     = ncbg_pkg::RNG_W;
    // Raw frame count must hold both the scaled duration and the 480-frame cap.
    localparam int FR_FULL_W = $clog2(FRAMES_PER_MS * ncbg_pkg::MAX_MS + 1);
    localparam int FR_RAW_W  = (FR_FULL_W > FRAME_W) ? FR_FULL_W : FRAME_W + 1;
    localparam int PROD_W    = 2 * SAMPLE_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV_GO   = 3'd1;
    localparam logic [2:0] ST_DIV_WAIT = 3'd2;
    localparam logic [2:0] ST_MULT     = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;

    logic [2:0]          state_reg;
    logic                sound_enabled_reg;
    logic [6:0]          volume_percent_reg;
    logic [RNG_W-1:0]    rng_word_reg;
    logic [FRAME_W-1:0]  frame_index_reg;
    logic [FRAME_W-1:0]  frame_total_reg;
    logic                busy_reg;

    logic [NUM_W-1:0]    num_reg;
    logic [SAMPLE_W-1:0] noise_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                active_reg;
    logic                last_reg;

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_data_reg;
    logic                m_active_reg;
    logic                m_last_reg;

    logic                in_xfer;
    logic                gated;
    logic                burst_live;
    logic [15:0]         ms_in;
    logic [15:0]         ms_clamped;
    logic [FR_RAW_W-1:0] frames_raw;
    logic [FRAME_W-1:0]  frames;
    logic [RNG_W-1:0]    x1;
    logic [RNG_W-1:0]    x2;
    logic [RNG_W-1:0]    rng_next;
    logic [FRAME_W-1:0]  frames_left;
    logic [FRAME_W-1:0]  index_inc;
    logic [AMP_W-1:0]    amp;
    logic [PROD_W-1:0]   prod_adj;
    logic [SAMPLE_W-1:0] sample_val;
    logic                slot_free;

    ncbg_pkg::div_req_t     div_req;
    logic                   div_done;
    logic [NUM_W-1:0]       div_quo;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // Start gating and burst length: clamp ms to 5..30, scale, cap at 480 frames.
    assign gated = !sound_enabled_reg || (volume_percent_reg == '0);
    assign ms_in = s_tdata[15:0];

    always_comb
    begin
        if (ms_in > 16'(ncbg_pkg::MAX_MS))
            ms_clamped = 16'(ncbg_pkg::MAX_MS);
        else if (ms_in < 16'(ncbg_pkg::MIN_MS))
            ms_clamped = 16'(ncbg_pkg::MIN_MS);
        else
            ms_clamped = ms_in;
        frames_raw = FR_RAW_W'(FRAMES_PER_MS) * ms_clamped[FR_RAW_W-1:0];
        if (frames_raw > FR_RAW_W'(ncbg_pkg::MAX_FRAMES))
            frames = FRAME_W'(ncbg_pkg::MAX_FRAMES);
        else if (frames_raw == '0)
            frames = FRAME_W'(1);
        else
            frames = frames_raw[FRAME_W-1:0];
    end

    // xorshift32 step with shifts 13, 17, 5.
    always_comb
    begin
        x1       = rng_word_reg ^ (rng_word_reg << 13);
        x2       = x1 ^ (x1 >> 17);
        rng_next = x2 ^ (x2 << 5);
    end

    assign burst_live  = busy_reg && (frame_total_reg != '0) &&
                         (frame_index_reg < frame_total_reg);
    assign frames_left = frame_total_reg - frame_index_reg;
    assign index_inc   = frame_index_reg + 1'b1;

    // Divider request: fire once the numerator is registered.
    always_comb
    begin
        div_req.start       = (state_reg == ST_DIV_GO);
        div_req.numerator   = num_reg;
        div_req.denominator = frame_total_reg;
    end

    ncbg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Saturate the envelope to 15 bits.
    assign amp = (div_quo[NUM_W-1:AMP_W] != '0) ? {AMP_W{1'b1}} : div_quo[AMP_W-1:0];

    // Divide by 32768 with truncation toward zero: bias negatives before the shift.
    assign prod_adj   = prod_reg[PROD_W-1] ? (prod_reg + PROD_W'(32767)) : prod_reg;
    assign sample_val = prod_adj[AMP_W +: SAMPLE_W];

    assign slot_free = !m_valid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enabled_reg  <= 1'b1;
            volume_percent_reg <= 7'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index[0])
                ncbg_pkg::CFG_SOUND_ENABLED:  sound_enabled_reg  <= cfg_data[0];
                ncbg_pkg::CFG_VOLUME_PERCENT: volume_percent_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Sequencer and burst state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rng_word_reg    <= RNG_W'(1);
            frame_index_reg <= '0;
            frame_total_reg <= '0;
            busy_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (s_tuser[0] == ncbg_pkg::CMD_START)
                        begin
                            // Arm or restart the burst unless sound is disabled or volume is zero.
                            if (!gated)
                            begin
                                rng_word_reg    <= s_tdata[47:16] | RNG_W'(1);
                                frame_total_reg <= frames;
                                frame_index_reg <= '0;
                                busy_reg        <= 1'b1;
                            end
                        end
                        else if (burst_live)
                        begin
                            rng_word_reg    <= rng_next;
                            frame_index_reg <= index_inc;
                            if (index_inc >= frame_total_reg)
                                busy_reg <= 1'b0;
                            state_reg <= ST_DIV_GO;
                        end
                        else
                        begin
                            // Idle tick: emit a silent sample.
                            busy_reg  <= 1'b0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                        state_reg <= ST_MULT;
                end
                ST_MULT:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_xfer && s_tuser[0] == ncbg_pkg::CMD_TICK)
        begin
            num_reg    <= NUM_W'(PEAK_AMPLITUDE) * NUM_W'(frames_left);
            noise_reg  <= rng_next[SAMPLE_W-1:0];
            prod_reg   <= '0;
            active_reg <= burst_live;
            last_reg   <= burst_live && (index_inc == frame_total_reg);
        end
        if (state_reg == ST_MULT)
            prod_reg <= PROD_W'($signed(noise_reg) * $signed({1'b0, amp}));
        if (state_reg == ST_EMIT && slot_free)
        begin
            m_data_reg   <= sample_val;
            m_active_reg <= active_reg;
            m_last_reg   <= last_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_active_reg;
    assign m_tlast    = m_last_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

    localparam int FRAMES_PER_MS  = 16;
    localparam int PEAK_AMPLITUDE = 18000;
    localparam int NOISE_SCALE    = 32768;
    // Leave margin on top of the sample latency during a burst.
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_CYCLES   = 600;

    // One input transfer: command plus the start-only fields.
    typedef struct {
        logic        cmd;
        logic [15:0] dur_ms;
        logic [31:0] seed;
    } click_item_t;

    // One output transfer.
    typedef struct {
        logic [15:0] sample;
        logic        active;
        logic        last;
    } click_sample_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // [15:0] duration_ms, [47:16] seed_value
    logic [0:0]  s_tuser = '0;   // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [15:0] sample
    logic [0:0]  m_tuser;        // [0] active
    logic        m_tlast;

    noise_click_burst_generator #(
        .FRAMES_PER_MS  (FRAMES_PER_MS),
        .PEAK_AMPLITUDE (PEAK_AMPLITUDE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Items waiting for the driver, and samples the burst model expects.
    click_item_t   item_q[$];
    click_sample_t sample_q[$];

    int n_queued      = 0;
    int n_accepted    = 0;
    int n_errors      = 0;
    int n_samples     = 0;
    int n_burst_ends  = 0;
    int n_bursts      = 0;
    int n_gated       = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int rx_hold       = 0;
    logic s_taken     = 1'b0;

    // Burst model state: registers, generator word, frame position.
    logic        mdl_enable;
    logic [6:0]  mdl_volume;
    logic [31:0] mdl_rng;
    int          mdl_frame;
    int          mdl_total;
    logic        mdl_busy;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #4_000_000;
        $display("noise_click_burst_generator test failed");
        $finish;
    end

    function automatic logic [31:0] xorshift32(input logic [31:0] w);
        logic [31:0] v;
        v = w ^ (w << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // Burst length in frames for a requested duration: clamp to 5..30 ms, cap the frames.
    function automatic int burst_frames(input logic [15:0] dur_ms);
        int ms;
        int frames;
        ms = dur_ms;
        if (ms > ncbg_pkg::MAX_MS) ms = ncbg_pkg::MAX_MS;
        if (ms < ncbg_pkg::MIN_MS) ms = ncbg_pkg::MIN_MS;
        frames = ms * FRAMES_PER_MS;
        if (frames > ncbg_pkg::MAX_FRAMES) frames = ncbg_pkg::MAX_FRAMES;
        return frames;
    endfunction

    // Advance the burst model by one accepted item; a tick queues its sample.
    task automatic advance_burst(input click_item_t it);
        click_sample_t res;
        int noise;
        int env;
        int prod;
        res = '{16'd0, 1'b0, 1'b0};
        if (it.cmd == ncbg_pkg::CMD_START)
        begin
            // Gated starts leave any running burst alone.
            if (!mdl_enable || mdl_volume == 7'd0)
            begin
                n_gated++;
                return;
            end
            mdl_total = burst_frames(it.dur_ms);
            mdl_rng   = it.seed | 32'd1;
            mdl_frame = 0;
            mdl_busy  = 1'b1;
            n_bursts++;
            return;
        end
        if (mdl_busy && mdl_total != 0 && mdl_frame < mdl_total)
        begin
            mdl_rng = xorshift32(mdl_rng);
            noise   = $signed(mdl_rng[15:0]);
            env     = PEAK_AMPLITUDE * (mdl_total - mdl_frame) / mdl_total;
            // int division truncates toward zero, as the block must
            prod    = noise * env / NOISE_SCALE;
            res.sample = prod[15:0];
            res.active = 1'b1;
            res.last   = (mdl_frame + 1 == mdl_total);
            mdl_frame++;
            if (mdl_frame >= mdl_total) mdl_busy = 1'b0;
        end
        else
        begin
            mdl_busy = 1'b0;
        end
        sample_q.push_back(res);
    endtask

    task automatic push_item(input logic cmd, input logic [15:0] dur_ms, input logic [31:0] seed);
        click_item_t it;
        it.cmd    = cmd;
        it.dur_ms = dur_ms;
        it.seed   = seed;
        item_q.push_back(it);
        n_queued++;
    endtask

    // Mostly well-formed bursts: a start, then ticks to its end plus a few idle ones,
    // or cut short by the next start. Lone random items in between act as noise.
    task automatic queue_bursts(input int count);
        int added;
        int r;
        int ticks;
        logic [15:0] dur;
        added = 0;
        while (added < count)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                push_item(1'($urandom_range(1)), 16'($urandom), $urandom);
                added++;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 80)      dur = 16'($urandom_range(8));
                else if (r < 92) dur = 16'($urandom_range(30, 9));
                else             dur = 16'($urandom);
                push_item(ncbg_pkg::CMD_START, dur, $urandom);
                added++;
                if ($urandom_range(3) == 0)
                    ticks = int'($urandom_range(burst_frames(dur) - 1));
                else
                    ticks = burst_frames(dur) + int'($urandom_range(3));
                for (int i = 0; i < ticks && added < count; i++)
                begin
                    // Tick fields are don't-care; randomize them anyway.
                    push_item(ncbg_pkg::CMD_TICK, 16'($urandom), $urandom);
                    added++;
                end
            end
        end
    endtask

    // Wait until every item is taken and every sample seen, then let the block settle.
    // Call at a falling edge.
    task automatic drain();
        while (n_accepted != n_queued || sample_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers on back-to-back cycles; hold cfg_we across them.
    task automatic write_regs(input logic enable, input logic [6:0] volume);
        cfg_we    <= 1'b1;
        cfg_index <= ncbg_pkg::CFG_SOUND_ENABLED;
        cfg_data  <= {6'd0, enable};
        mdl_enable = enable;
        @(negedge clk);
        cfg_index <= ncbg_pkg::CFG_VOLUME_PERCENT;
        cfg_data  <= volume;
        mdl_volume = volume;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Driver: offer the next item at the falling edge once the previous one is taken.
    // Valid never drops while an item is waiting for ready.
    always @(negedge clk)
    begin : driver
        click_item_t cur;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_taken)
        begin
            if (item_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                cur = item_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur.cmd;
                s_tdata  <= {cur.seed, cur.dur_ms};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random ready, or a long hold-off counted down here.
    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: check each sample transfer against the oldest expectation, then feed
    // each accepted input transfer to the burst model.
    always @(posedge clk)
    begin : monitor
        click_sample_t want;
        click_item_t   got;
        if (rst_n)
        begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (sample_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected sample transfer: expected none, actual sample=%0d active=%0b last=%0b",
                             $time, $signed(m_tdata), m_tuser[0], m_tlast);
                end
                else
                begin
                    want = sample_q.pop_front();
                    n_samples++;
                    if (want.last) n_burst_ends++;
                    if (m_tdata !== want.sample)
                    begin
                        n_errors++;
                        $display("%0t: sample mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.sample), $signed(m_tdata));
                    end
                    if (m_tuser[0] !== want.active)
                    begin
                        n_errors++;
                        $display("%0t: active mismatch: expected %0b, actual %0b",
                                 $time, want.active, m_tuser[0]);
                    end
                    if (m_tlast !== want.last)
                    begin
                        n_errors++;
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                got.cmd    = s_tuser[0];
                got.dur_ms = s_tdata[15:0];
                got.seed   = s_tdata[47:16];
                advance_burst(got);
                n_accepted <= n_accepted + 1;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        // Reset state of the model matches the block's reset.
        mdl_enable = 1'b1;
        mdl_volume = 7'd50;
        mdl_rng    = 32'd1;
        mdl_frame  = 0;
        mdl_total  = 0;
        mdl_busy   = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset settings; sender idles lightly, receiver heavily.
        tx_idle_pct = 12;
        rx_idle_pct = 71;
        // idle ticks, with the ignored fields at both extremes
        push_item(ncbg_pkg::CMD_TICK, 16'h0000, 32'h0000_0000);
        push_item(ncbg_pkg::CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF);
        // zero duration clamps to the minimum, zero seed is forced odd
        push_item(ncbg_pkg::CMD_START, 16'd0, 32'h0000_0000);
        repeat (3) push_item(ncbg_pkg::CMD_TICK, 16'd0, 32'd0);
        // restart a running burst at the longest duration
        push_item(ncbg_pkg::CMD_START, 16'hFFFF, 32'hFFFF_FFFF);
        repeat (2) push_item(ncbg_pkg::CMD_TICK, 16'd0, 32'd0);
        // durations just outside and at both clamp limits
        push_item(ncbg_pkg::CMD_START, 16'd4, 32'h8000_0000);
        push_item(ncbg_pkg::CMD_TICK, 16'd0, 32'd0);
        push_item(ncbg_pkg::CMD_START, 16'd31, 32'h0000_0002);
        push_item(ncbg_pkg::CMD_TICK, 16'd0, 32'd0);
        push_item(ncbg_pkg::CMD_START, 16'd5, $urandom);
        push_item(ncbg_pkg::CMD_TICK, 16'd0, 32'd0);
        push_item(ncbg_pkg::CMD_START, 16'd30, $urandom);
        push_item(ncbg_pkg::CMD_TICK, 16'd0, 32'd0);
        // leave a burst running across the next register change
        push_item(ncbg_pkg::CMD_START, 16'd6, $urandom);
        repeat (2) push_item(ncbg_pkg::CMD_TICK, 16'd0, 32'd0);
        drain();

        // Volume with every bit set: only enables bursts.
        write_regs(1'b1, 7'h7F);
        queue_bursts(300);
        // Hold off the receiver for a long stretch so the block backs up its input.
        while (n_accepted < n_queued - 250) @(posedge clk);
        rx_hold = STALL_CYCLES;
        @(negedge clk);
        // Finish on a long burst still running when sound goes off.
        push_item(ncbg_pkg::CMD_START, 16'd30, $urandom);
        repeat (5) push_item(ncbg_pkg::CMD_TICK, 16'($urandom), $urandom);
        drain();

        // Sound disabled: starts are dropped, a running burst continues.
        tx_idle_pct = 71;
        rx_idle_pct = 12;
        write_regs(1'b0, 7'd100);
        queue_bursts(150);
        drain();

        // Volume zero gates starts as well.
        write_regs(1'b1, 7'd0);
        queue_bursts(150);
        drain();

        // Smallest nonzero volume.
        write_regs(1'b1, 7'd1);
        queue_bursts(300);
        drain();

        // Full volume, no idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_regs(1'b1, 7'd100);
        queue_bursts(600);
        drain();

        $display("Covered %0d input transfers: %0d bursts armed, %0d starts gated off.",
                 n_accepted, n_bursts, n_gated);
        $display("Checked %0d samples, %0d of them burst ends; %0d mismatches.",
                 n_samples, n_burst_ends, n_errors);
        if (n_errors == 0 && sample_q.size() == 0)
            $display("noise_click_burst_generator test passed");
        else
            $display("noise_click_burst_generator test failed");
        $finish;
    end

endmodule

// ===== noise_click_burst_generator.f =====
sv/ncbg_pkg.sv
sv/ncbg_div.sv
sv/noise_click_burst_generator.sv
dv/tb.sv
